@@ hw/rtl/shs_pkg.sv @@
// Package for the streaming SHA-256 hasher: payload structs, controller/datapath
// command and status types, round constants, initial hash values, helper functions.
// No dependencies.
package shs_pkg;

	localparam int OP_W = 1;

	// operation codes of an input word
	localparam logic [OP_W-1:0] OP_ABSORB = 1'b0;
	localparam logic [OP_W-1:0] OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] FILL_LEN_POS = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [7:0]      data_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} result_t;

	// source of a byte pushed into the block buffer
	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_PAD,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       push;
		byte_sel_t  byte_sel;
		logic [2:0] len_idx;
		logic       load_vars;
		logic       round;
		logic       add;
		logic       reset_chain;
		logic [2:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
	} dp_stat_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sml_s0(input logic [31:0] x);
		sml_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sml_s1(input logic [31:0] x);
		sml_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

@@ hw/rtl/shs_datapath.sv @@
// Datapath of the SHA-256 hasher: byte packer, 16-word block/schedule shift line,
// one-round-per-cycle compression, chaining words and bit counter.
// Depends on shs_pkg.
module shs_datapath
	import shs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  logic [7:0] data_byte,
	output dp_stat_t stat,
	output result_t  result
);

	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [23:0] acc_q;
	logic [31:0] w_q [16];
	logic [31:0] chain_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0]  round_q;

	logic [7:0]  push_byte;
	logic [31:0] w_new, t1, t2;
	logic [5:0]  len_shift;

	// byte source
	assign len_shift = {3'd7 - cmd.len_idx, 3'b000};
	always_comb begin
		case (cmd.byte_sel)
			SEL_DATA: push_byte = data_byte;
			SEL_PAD:  push_byte = PAD_BYTE;
			SEL_ZERO: push_byte = 8'h00;
			SEL_LEN:  push_byte = 8'(bits_q >> len_shift);
			default:  push_byte = 8'h00;
		endcase
	end

	// message schedule and round arithmetic
	assign w_new = sml_s1(w_q[14]) + w_q[9] + sml_s0(w_q[1]) + w_q[0];
	assign t1 = h_q + big_s1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + K_TAB[round_q] + w_q[0];
	assign t2 = big_s0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	// fill count and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
		end else if (cmd.reset_chain) begin
			fill_q <= '0;
			bits_q <= '0;
		end else if (cmd.push) begin
			fill_q <= fill_q + 6'd1;
			if (cmd.byte_sel == SEL_DATA) begin
				bits_q <= bits_q + 64'd8;
			end
		end
	end

	// byte packer and block/schedule shift line
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= {acc_q[15:0], push_byte};
			if (fill_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= {acc_q, push_byte};
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2]; d_q <= chain_q[3];
			e_q <= chain_q[4]; f_q <= chain_q[5]; g_q <= chain_q[6]; h_q <= chain_q[7];
		end else if (cmd.round) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	// round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.load_vars) begin
			round_q <= '0;
		end else if (cmd.round) begin
			round_q <= round_q + 6'd1;
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
		end else if (cmd.reset_chain) begin
			chain_q <= H_INIT;
		end else if (cmd.add) begin
			chain_q[0] <= chain_q[0] + a_q; chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q; chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q; chain_q[5] <= chain_q[5] + f_q;
			chain_q[6] <= chain_q[6] + g_q; chain_q[7] <= chain_q[7] + h_q;
		end
	end

	assign stat.fill = fill_q;
	assign stat.round_last = (round_q == ROUND_LAST);

	assign result.digest_word = chain_q[cmd.out_idx];
	assign result.word_index = cmd.out_idx;
	assign result.last_word = (cmd.out_idx == WORD_LAST);

	// a push that completes a block must start a compression
	a_full_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && fill_q == FILL_LAST |-> cmd.load_vars)
		else $error("block completed without compression start");

	// compression starts from round zero
	a_load_round0: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_vars |=> round_q == 6'd0)
		else $error("round counter not cleared on load");

	// the shift line is never fed and rotated in the same cycle
	a_push_round: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.round))
		else $error("byte push during a round");

endmodule

@@ hw/rtl/shs_ctrl.sv @@
// Controller of the SHA-256 hasher: handshakes, padding sequence, round sequencing
// and digest output. Drives the datapath through dp_cmd_t; depends on shs_pkg.
module shs_ctrl
	import shs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  item_t    item,
	output logic     result_valid,
	input  logic     result_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t     state_q, state_d;
	logic       fin_q, len_done_q;
	logic [2:0] len_q, emit_q;
	logic       take;

	assign take = item_valid && (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.operation == OP_FINISH) begin
						state_d = ST_PAD80;
					end else if (stat.fill == FILL_LAST) begin
						state_d = ST_ROUND;
					end
				end
			end
			ST_PAD80: state_d = (stat.fill == FILL_LAST) ? ST_ROUND : ST_PADZ;
			ST_PADZ: begin
				if (stat.fill == FILL_LEN_POS) begin
					state_d = ST_LEN;
				end else if (stat.fill == FILL_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_LEN: if (len_q == WORD_LAST) state_d = ST_ROUND;
			ST_ROUND: if (stat.round_last) state_d = ST_ADD;
			ST_ADD: begin
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (len_done_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_PADZ;
				end
			end
			ST_EMIT: if (!result_stall && emit_q == WORD_LAST) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.byte_sel = SEL_DATA;
		cmd.len_idx = len_q;
		cmd.out_idx = emit_q;
		item_stall = (state_q != ST_IDLE);
		result_valid = (state_q == ST_EMIT);
		case (state_q)
			ST_IDLE: begin
				if (item_valid && item.operation == OP_ABSORB) begin
					cmd.push = 1'b1;
					cmd.load_vars = (stat.fill == FILL_LAST);
				end
			end
			ST_PAD80: begin
				cmd.push = 1'b1;
				cmd.byte_sel = SEL_PAD;
				cmd.load_vars = (stat.fill == FILL_LAST);
			end
			ST_PADZ: begin
				cmd.byte_sel = SEL_ZERO;
				cmd.push = (stat.fill != FILL_LEN_POS);
				cmd.load_vars = (stat.fill == FILL_LAST);
			end
			ST_LEN: begin
				cmd.push = 1'b1;
				cmd.byte_sel = SEL_LEN;
				cmd.load_vars = (stat.fill == FILL_LAST);
			end
			ST_ROUND: cmd.round = 1'b1;
			ST_ADD: cmd.add = 1'b1;
			ST_EMIT: cmd.reset_chain = !result_stall && (emit_q == WORD_LAST);
			default: ;
		endcase
	end

	// state and sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q <= 1'b0;
			len_done_q <= 1'b0;
			len_q <= '0;
			emit_q <= '0;
		end else begin
			state_q <= state_d;
			if (take && item.operation == OP_FINISH) begin
				fin_q <= 1'b1;
				len_q <= '0;
				len_done_q <= 1'b0;
				emit_q <= '0;
			end
			if (state_q == ST_LEN) begin
				len_q <= len_q + 3'd1;
				if (len_q == WORD_LAST) len_done_q <= 1'b1;
			end
			if (state_q == ST_EMIT && !result_stall) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == WORD_LAST) begin
					fin_q <= 1'b0;
					len_done_q <= 1'b0;
				end
			end
		end
	end

	// the last digest word returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && emit_q == WORD_LAST |=> state_q == ST_IDLE)
		else $error("not idle after last digest word");

	// chaining update only right after the final round
	a_add_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && stat.round_last |=> state_q == ST_ADD)
		else $error("final round not followed by chain update");

	// digest is shown only once the length is in
	a_emit_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> len_done_q && fin_q)
		else $error("digest output before length block");

endmodule

@@ hw/rtl/sha256_stream_hasher_core.sv @@
// Streaming SHA-256 hasher, top level. An absorb word is taken while idle; the byte that fills a
// block starts 64 rounds (one per cycle in the shared round unit), then the chain add.
// Finish: the finish word, then the padding and length bytes with no push at offset 56, the
// compression of each block (one or two), then 8 digest words at one per unstalled cycle.
// Reset (arst_n, async, active low): initial hash values, empty buffer, zero bit count.
// Depends on shs_pkg, shs_ctrl, shs_datapath.
module sha256_stream_hasher_core
	import shs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	shs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	shs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (item.data_byte),
		.stat      (stat),
		.result    (result)
	);

endmodule
